// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants for the fit partition allocator.
// No dependencies; imported by the top level, the checker and the testbench.
package fpa_pkg;

  localparam int CORE_COUNT = 4;
  localparam int CORE_IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int ID_W       = 8;
  localparam int LOAD_W     = 17;
  localparam int SUM_W      = LOAD_W + 1;
  localparam int OUT_IDX_W  = 4;

  localparam logic [LOAD_W-1:0]     CAPACITY  = LOAD_W'(65536);
  localparam logic [CORE_IDX_W-1:0] LAST_CORE = CORE_IDX_W'(CORE_COUNT - 1);

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   task_id;
    logic [LOAD_W-1:0] task_load;
  } task_word_t;

  typedef struct packed {
    logic [ID_W-1:0]      task_id_out;
    logic                 placed;
    logic [OUT_IDX_W-1:0] core_index;
    logic [LOAD_W-1:0]    core_load_out;
  } result_word_t;

endpackage

// ===== rtl/core/fpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fit_partition_allocator.sv =====
// Top level of the fit partition allocator: scan sequencer and result register.
// Depends on fpa_pkg and fpa_ram.
//
// Usage:
//   Task channel (task_valid / task_stall / task_word): a word is taken at a
//   rising edge with task_valid high and task_stall low. opcode OP_CLEAR
//   zeroes every core load at once and yields no result; OP_PLACE offers
//   task_load to the cores under the current fit policy.
//   Result channel (result_valid / result_stall / result_word): one word per
//   place, held in an output register until taken.
//   Config: cfg_wr_en writes cfg_wr_data into the fit policy (0 first, 1 best,
//   2 worst, 3 acts as first). Write only while the block is idle.
// Sequence:
//   A place is accepted while idle; the cores are then scanned one at a time
//   in order, set by the single read port of the load RAM. The result is
//   visible the cycle after the last core is scanned.
//   A clear is accepted only while idle and starts no scan.
// Reset (rst, synchronous): all loads read as zero, policy first-fit, no
//   result pending. A stalled result word holds; the scan then waits in its
//   last step and the task channel stays stalled until the word is taken.
module fit_partition_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 task_valid,
  output logic                 task_stall,
  input  fpa_pkg::task_word_t  task_word,
  output logic                 result_valid,
  input  logic                 result_stall,
  output fpa_pkg::result_word_t result_word,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_wr_data
);
  import fpa_pkg::*;

  // control state
  state_t                  state, state_next;
  logic [CORE_IDX_W-1:0]   scan_idx;
  logic [CORE_COUNT-1:0]   core_valid;   // entry written since last clear
  logic [1:0]              fit_policy;

  // latched task and running pick
  logic [ID_W-1:0]         task_id;
  logic [LOAD_W-1:0]       task_load;
  logic                    found;
  logic [CORE_IDX_W-1:0]   pick;
  logic [LOAD_W-1:0]       pick_sum;

  // RAM port
  logic                    ram_we;
  logic [CORE_IDX_W-1:0]   ram_raddr;
  logic [LOAD_W-1:0]       ram_rdata;

  // FSM outputs
  logic accept;
  logic clear_now;
  logic start_scan;
  logic last_step;
  logic advance;
  logic finish;

  // per-core evaluation
  logic [LOAD_W-1:0] cur_load;
  logic [SUM_W-1:0]  sum;
  logic              fits;
  logic              better;
  logic              take;
  logic              found_fin;
  logic [CORE_IDX_W-1:0] pick_fin;
  logic [LOAD_W-1:0] pick_sum_fin;

  fpa_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (CORE_COUNT)
  ) u_load_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_fin),
    .wdata (pick_sum_fin),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Loads of cores not written since the last clear read as zero.
  assign cur_load = core_valid[scan_idx] ? ram_rdata : '0;
  assign sum      = {1'b0, cur_load} + {1'b0, task_load};
  assign fits     = (sum <= {1'b0, CAPACITY});

  always_comb begin
    case (fit_policy)
      POL_FIRST: better = 1'b0;
      POL_BEST:  better = (sum[LOAD_W-1:0] > pick_sum);
      POL_WORST: better = (sum[LOAD_W-1:0] < pick_sum);
      default:   better = 1'b0;
    endcase
  end

  assign take         = fits && (!found || better);
  assign found_fin    = found || take;
  assign pick_fin     = take ? scan_idx : pick;
  assign pick_sum_fin = take ? sum[LOAD_W-1:0] : pick_sum;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (task_valid && task_word.opcode == OP_PLACE) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    task_stall = 1'b1;
    last_step  = 1'b0;
    advance    = 1'b0;
    ram_raddr  = '0;
    case (state)
      ST_IDLE: begin
        task_stall = 1'b0;
      end
      ST_SCAN: begin
        last_step = (scan_idx == LAST_CORE);
        // the last step waits for a free result register
        advance   = !last_step || !(result_valid && result_stall);
        // hold the address while waiting so read data stays put
        ram_raddr = (last_step || !advance) ? scan_idx : scan_idx + 1'b1;
      end
      default: begin
        task_stall = 1'b1;
      end
    endcase
  end

  assign accept     = task_valid && !task_stall;
  assign clear_now  = accept && task_word.opcode == OP_CLEAR;
  assign start_scan = accept && task_word.opcode == OP_PLACE;
  assign finish     = last_step && advance;
  assign ram_we     = finish && found_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_idx     <= '0;
      core_valid   <= '0;
      fit_policy   <= POL_FIRST;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        fit_policy <= cfg_wr_data;
      end
      if (clear_now) begin
        core_valid <= '0;
      end else if (ram_we) begin
        core_valid[pick_fin] <= 1'b1;
      end
      if (start_scan) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (state == ST_SCAN && advance && !last_step) begin
        scan_idx <= scan_idx + 1'b1;
        found    <= found_fin;
      end
      if (finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_scan) begin
      task_id   <= task_word.task_id;
      task_load <= task_word.task_load;
    end
    if (state == ST_SCAN && advance && !last_step) begin
      pick     <= pick_fin;
      pick_sum <= pick_sum_fin;
    end
    if (finish) begin
      result_word.task_id_out   <= task_id;
      result_word.placed        <= found_fin;
      result_word.core_index    <= found_fin ? OUT_IDX_W'(pick_fin) : '0;
      result_word.core_load_out <= found_fin ? pick_sum_fin : '0;
    end
  end

`ifndef SYNTH
  a_placed_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.placed) |->
      (result_word.core_load_out <= CAPACITY &&
       result_word.core_index < OUT_IDX_W'(CORE_COUNT)))
    else $error("placed result out of range");

  a_unplaced_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_word.placed) |->
      (result_word.core_index == '0 && result_word.core_load_out == '0))
    else $error("unplaced result carries nonzero fields");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear_now |=> (core_valid == '0))
    else $error("clear left a core loaded");

  a_write_at_end: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_SCAN && scan_idx == LAST_CORE &&
                !(result_valid && result_stall)))
    else $error("load write outside the final scan step");

  a_scan_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !last_step) |=> (scan_idx == $past(scan_idx) + 1'b1))
    else $error("scan skipped a core");
`endif

endmodule

// ===== test/fpa_checker.sv =====
// Result checker for the fit partition allocator: predicts every placement and
// compares it with the result channel. Depends on fpa_pkg only.
module fpa_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  task_valid,
  input  logic                  task_stall,
  input  fpa_pkg::task_word_t   task_word,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  fpa_pkg::result_word_t result_word,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_wr_data,
  output int                    fail_count,
  output int                    placements_pending,
  output int                    places_seen,
  output int                    placed_seen,
  output int                    clears_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow of the block's state.
  logic [LOAD_W-1:0] core_loads [CORE_COUNT];
  logic [1:0]        fit_policy_q;

  result_word_t placements_due [$];
  int           mismatches;

  // Bin packing decision for one task; updates the shadow loads.
  function automatic result_word_t choose_core(task_word_t w);
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] chosen_sum;
    logic             found;
    int               chosen;
    result_word_t     r;
    found      = 1'b0;
    chosen     = 0;
    chosen_sum = '0;
    for (int c = 0; c < CORE_COUNT; c++) begin
      // full-width sum, so loads above one never fit
      trial = SUM_W'(core_loads[c]) + SUM_W'(w.task_load);
      if (trial <= SUM_W'(CAPACITY)) begin
        if (!found ||
            (fit_policy_q == POL_BEST  && trial > chosen_sum) ||
            (fit_policy_q == POL_WORST && trial < chosen_sum)) begin
          found      = 1'b1;
          chosen     = c;
          chosen_sum = trial;
        end
      end
    end
    r.task_id_out = w.task_id;
    r.placed      = found;
    r.core_index  = found ? OUT_IDX_W'(chosen) : '0;
    r.core_load_out = found ? LOAD_W'(chosen_sum) : '0;
    if (found) core_loads[chosen] = LOAD_W'(chosen_sum);
    return r;
  endfunction

  initial begin
    fail_count         = 0;
    placements_pending = 0;
    places_seen        = 0;
    placed_seen        = 0;
    clears_seen        = 0;
    mismatches         = 0;
    fit_policy_q       = POL_FIRST;
    foreach (core_loads[c]) core_loads[c] = '0;
  end

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      foreach (core_loads[c]) core_loads[c] = '0;
      fit_policy_q = POL_FIRST;
      placements_due.delete();
    end else begin
      // results first: they always belong to older words
      if (result_valid && !result_stall) begin
        if (placements_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result for task %0d with nothing outstanding", $realtime,
                     result_word.task_id_out);
        end else begin
          want = placements_due.pop_front();
          places_seen <= places_seen + 1;
          if (want.placed) placed_seen <= placed_seen + 1;
          if (result_word.task_id_out !== want.task_id_out ||
              result_word.placed !== want.placed ||
              result_word.core_index !== want.core_index ||
              result_word.core_load_out !== want.core_load_out) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"%0t: mismatch exp id=%0d placed=%0b core=%0d load=%0d",
                        " got id=%0d placed=%0b core=%0d load=%0d"}, $realtime,
                       want.task_id_out, want.placed, want.core_index,
                       want.core_load_out, result_word.task_id_out,
                       result_word.placed, result_word.core_index,
                       result_word.core_load_out);
          end
        end
      end
      if (cfg_wr_en) fit_policy_q = cfg_wr_data;
      if (task_valid && !task_stall) begin
        if (task_word.opcode == OP_CLEAR) begin
          foreach (core_loads[c]) core_loads[c] = '0;
          clears_seen <= clears_seen + 1;
        end else begin
          placements_due.push_back(choose_core(task_word));
        end
      end
    end
    fail_count         <= mismatches;
    placements_pending <= placements_due.size();
  end

endmodule

// ===== test/fit_partition_allocator_test.sv =====
// Testbench top for the fit partition allocator: clock, reset, task stimulus,
// result back-pressure and verdict. Depends on fpa_pkg, the block and fpa_checker.
module fit_partition_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 8;
  // settle after the drain so a trailing clear finishes before config
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASES        = 12;
  localparam int          PHASE_WORDS   = 155;
  // quiet tail: the last phases run with no idling on either side
  localparam int          QUIET_PHASES  = 2;
  // policy code three, which the block treats as first-fit
  localparam logic [1:0]  POL_ALIAS     = 2'd3;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         task_valid   = 1'b0;
  logic         task_stall;
  task_word_t   task_word    = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result_word;
  logic         cfg_wr_en    = 1'b0;
  logic [1:0]   cfg_wr_data  = '0;

  int fail_count;
  int placements_pending;
  int places_seen;
  int placed_seen;
  int clears_seen;

  // stimulus controls shared with the stall process
  bit gaps_on      = 1'b1;
  bit hold_request = 1'b0;
  int hold_count   = 0;
  int policy_writes = 0;

  fit_partition_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (task_valid),
    .task_stall   (task_stall),
    .task_word    (task_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  fpa_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .task_valid         (task_valid),
    .task_stall         (task_stall),
    .task_word          (task_word),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .result_word        (result_word),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .placements_pending (placements_pending),
    .places_seen        (places_seen),
    .placed_seen        (placed_seen),
    .clears_seen        (clears_seen)
  );

  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Hard stop. Slowest legal run is roughly 1900 words, each paying a sender
  // gap, the scan and a receiver stall, plus the long hold; that is well
  // under 5 ms.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side back-pressure. Random stall bursts while gaps are on; a
  // long hold on request so the scan and the input back up behind the
  // result register.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_stall <= 1'b0;
        hold_request = 1'b0;
        hold_count++;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Offer one word, maybe after an idle burst, and return at the first edge
  // with task_stall low after it. Valid stays high across back-to-back words.
  task automatic send_word(input task_word_t w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      task_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    task_valid <= 1'b1;
    task_word  <= w;
    do @(posedge clk); while (task_stall);
  endtask

  task automatic offer_place(input logic [ID_W-1:0] id, input logic [LOAD_W-1:0] load);
    task_word_t w;
    w.opcode    = OP_PLACE;
    w.task_id   = id;
    w.task_load = load;
    send_word(w);
  endtask

  task automatic offer_clear();
    task_word_t w;
    w.opcode    = OP_CLEAR;
    w.task_id   = ID_W'($urandom_range(0, 255));
    w.task_load = LOAD_W'($urandom_range(0, 131071));
    send_word(w);
  endtask

  // Drop valid and let every outstanding placement drain, then give a
  // trailing clear time to finish as well.
  task automatic wait_quiet();
    @(negedge clk);
    task_valid <= 1'b0;
    while (placements_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Policy register is only touched with the block idle.
  task automatic write_policy(input logic [1:0] code);
    wait_quiet();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    policy_writes++;
  endtask

  // Mix of sizes: many small and mid tasks so cores fill over several words,
  // plus exact one, zero, and loads above one that can never fit.
  function automatic logic [LOAD_W-1:0] random_load();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 35)      return LOAD_W'($urandom_range(0, 8192));
    else if (kind < 65) return LOAD_W'($urandom_range(8192, 40000));
    else if (kind < 85) return LOAD_W'($urandom_range(0, 65536));
    else if (kind < 90) return CAPACITY;
    else if (kind < 94) return '0;
    else                return LOAD_W'($urandom_range(65537, 131071));
  endfunction

  initial begin
    logic [1:0] phase_policy [PHASES];
    phase_policy = '{POL_FIRST, POL_BEST, POL_WORST, POL_ALIAS, POL_BEST, POL_WORST,
                     POL_FIRST, POL_WORST, POL_BEST, POL_ALIAS, POL_BEST, POL_WORST};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: first-fit ----
    write_policy(POL_FIRST);
    offer_clear();
    offer_place(8'd0, 17'd65536);     // exact fit on an empty core
    offer_place(8'd255, 17'd0);       // zero load fits even a full core
    offer_place(8'd1, 17'd131071);    // largest encodable load: never fits
    offer_place(8'd2, 17'd65537);     // just above one
    offer_place(8'd3, 17'd32768);
    offer_place(8'd4, 17'd32768);     // fills core 1 to exactly one
    offer_place(8'd5, 17'd1);
    offer_place(8'd6, 17'd65535);     // tops core 2 up to exactly one
    offer_place(8'd7, 17'd65535);

    // ---- directed: best-fit, tightest resulting load wins ----
    write_policy(POL_BEST);
    offer_clear();
    offer_place(8'd8, 17'd16384);
    offer_place(8'd9, 17'd40000);
    offer_place(8'd10, 17'd30000);
    offer_place(8'd11, 17'd20000);

    // ---- directed: worst-fit, emptiest resulting load wins ----
    write_policy(POL_WORST);
    offer_clear();
    offer_place(8'd12, 17'd50000);
    offer_place(8'd13, 17'd10000);
    offer_place(8'd14, 17'd10000);
    offer_place(8'd15, 17'd60000);

    // ---- directed: code three acts as first-fit ----
    write_policy(POL_ALIAS);
    offer_place(8'd16, 17'd5000);
    offer_place(8'd17, 17'd5000);

    // ---- random phases ----
    for (int p = 0; p < PHASES; p++) begin
      if (p >= PHASES - QUIET_PHASES) gaps_on = 1'b0;
      write_policy((p >= 6 && p % 3 == 0) ? 2'($urandom_range(0, 3)) : phase_policy[p]);
      // receiver holds off while the sender keeps pushing
      if (p == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 19) == 0) offer_clear();
        else offer_place(ID_W'($urandom_range(0, 255)), random_load());
      end
    end

    wait_quiet();
    $display("Checked %0d placements (%0d placed, %0d unschedulable), %0d clears,",
             places_seen, placed_seen, places_seen - placed_seen, clears_seen);
    $display("%0d policy writes and %0d long receiver holds", policy_writes, hold_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fpa_pkg.sv
rtl/core/fpa_ram.sv
rtl/core/fit_partition_allocator.sv
test/fpa_checker.sv
test/fit_partition_allocator_test.sv
